/* design/f2x_pkg.sv */
package f2x_pkg;

  localparam int FloatWidth = 32;
  localparam int FixedWidth = 32;
  localparam int SigWidth   = 24;
  localparam int MagWidth   = 31;
  localparam int ShiftWidth = 5;

  localparam logic [7:0] EXP_FLUSH_BELOW = 8'd109;
  localparam logic [7:0] EXP_SATURATE_AT = 8'd141;
  localparam logic [7:0] EXP_UNIT_SHIFT  = 8'd133;

  localparam logic [FixedWidth-1:0] FIX_MOST_NEG = 32'h8000_0000;
  localparam logic [FixedWidth-1:0] FIX_MOST_POS = 32'h7fff_ffff;

  typedef struct packed {
    logic                  neg;
    logic                  zero;
    logic                  sat;
    logic                  left;
    logic [ShiftWidth-1:0] shamt;
    logic [SigWidth-1:0]   sig;
  } dec_t;

  typedef struct packed {
    logic                neg;
    logic                zero;
    logic                sat;
    logic [MagWidth-1:0] mag;
    logic                rnd;
    logic                sticky;
  } shf_t;

endpackage

/* design/f2x_float_if.sv */
interface f2x_float_if;
  logic        valid;
  logic        ready;
  logic [31:0] float_bits;

  modport source (output valid, output float_bits, input ready);
  modport sink (input valid, input float_bits, output ready);
endinterface

/* design/f2x_fixed_if.sv */
interface f2x_fixed_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] fixed_value;

  modport source (output valid, output fixed_value, input ready);
  modport sink (input valid, input fixed_value, output ready);
endinterface

/* design/f2x_decode.sv */
module f2x_decode (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [f2x_pkg::FloatWidth-1:0]    in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output f2x_pkg::dec_t                     out_data
);
  import f2x_pkg::*;

  logic [7:0] expo;
  dec_t       dec;

  always_comb begin
    expo      = in_data[30:23];
    dec.neg   = in_data[31];
    dec.zero  = expo < EXP_FLUSH_BELOW;
    dec.sat   = expo >= EXP_SATURATE_AT;
    dec.left  = expo >= EXP_UNIT_SHIFT;
    dec.shamt = dec.left ? ShiftWidth'(expo - EXP_UNIT_SHIFT)
                         : ShiftWidth'(EXP_UNIT_SHIFT - expo);
    dec.sig   = {1'b1, in_data[22:0]};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= dec;
    end
  end
endmodule

/* design/f2x_shift.sv */
module f2x_shift (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  f2x_pkg::dec_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output f2x_pkg::shf_t out_data
);
  import f2x_pkg::*;

  logic [ShiftWidth-1:0] rnd_idx;
  logic [SigWidth-1:0]   low_mask;
  shf_t                  shf;

  always_comb begin
    rnd_idx    = in_data.shamt - ShiftWidth'(1);
    low_mask   = (SigWidth'(1) << rnd_idx) - SigWidth'(1);
    shf.neg    = in_data.neg;
    shf.zero   = in_data.zero;
    shf.sat    = in_data.sat;
    if (in_data.left) begin
      shf.mag    = MagWidth'(in_data.sig) << in_data.shamt[2:0];
      shf.rnd    = 1'b0;
      shf.sticky = 1'b0;
    end else begin
      shf.mag    = MagWidth'(in_data.sig >> in_data.shamt);
      shf.rnd    = (rnd_idx < ShiftWidth'(SigWidth)) ? in_data.sig[rnd_idx] : 1'b0;
      shf.sticky = |(in_data.sig & low_mask);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= shf;
    end
  end
endmodule

/* design/f2x_round.sv */
module f2x_round (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  f2x_pkg::shf_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [f2x_pkg::FixedWidth-1:0] out_data
);
  import f2x_pkg::*;

  logic                  up;
  logic [FixedWidth-1:0] mag;
  logic [FixedWidth-1:0] res;

  always_comb begin
    up  = in_data.rnd && (in_data.sticky || in_data.mag[0]);
    mag = FixedWidth'(in_data.mag) + FixedWidth'(up);
    if (in_data.zero) begin
      res = '0;
    end else if (in_data.sat) begin
      res = in_data.neg ? FIX_MOST_NEG : FIX_MOST_POS;
    end else begin
      res = in_data.neg ? (FixedWidth'(0) - mag) : mag;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= res;
    end
  end
endmodule

/* design/float_to_fixed_converter.sv */
// Single-precision float to Q14.17 signed fixed-point converter.
//
// float_in carries the raw 32-bit IEEE pattern (float_bits); fixed_out
// carries the 32-bit two's complement result (fixed_value) with 17
// fraction bits, rounded to nearest even. Tiny values flush to zero,
// overflow, infinity and NaN saturate to the signed extremes.
//
// Three register stages: decode, align shift, round/negate. One transfer
// per cycle is sustained while fixed_out.ready stays high.
//
// Reset (rst, synchronous) clears the stage valid bits; nothing else is
// held. When fixed_out.ready is low, the result stays in the last stage
// and earlier stages keep filling; float_in.ready drops once all three
// stages hold data. Ready runs back combinationally through the stages.
module float_to_fixed_converter (
  input logic         clk,
  input logic         rst,
  f2x_float_if.sink   float_in,
  f2x_fixed_if.source fixed_out
);
  import f2x_pkg::*;

  logic                  dec_valid;
  logic                  dec_ready;
  dec_t                  dec_data;
  logic                  shf_valid;
  logic                  shf_ready;
  shf_t                  shf_data;
  logic [FixedWidth-1:0] res_data;

  f2x_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (float_in.valid),
    .in_ready  (float_in.ready),
    .in_data   (float_in.float_bits),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_data  (dec_data)
  );

  f2x_shift u_shift (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (shf_valid),
    .out_ready (shf_ready),
    .out_data  (shf_data)
  );

  f2x_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (shf_valid),
    .in_ready  (shf_ready),
    .in_data   (shf_data),
    .out_valid (fixed_out.valid),
    .out_ready (fixed_out.ready),
    .out_data  (res_data)
  );

  assign fixed_out.fixed_value = signed'(res_data);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (float_in.valid && float_in.ready) ##1 fixed_out.ready ##1 fixed_out.ready
      |=> fixed_out.valid)
    else $error("transfer did not reach output in 3 cycles");

  a_full_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !float_in.ready |-> (fixed_out.valid && !fixed_out.ready))
    else $error("input stalled without output backpressure");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !fixed_out.valid)
    else $error("output valid right after reset");

endmodule

/* sim/float_to_fixed_converter_tb.sv */
module float_to_fixed_converter_tb;
  import f2x_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [FixedWidth-1:0] fixed_t;

  class fixed_scoreboard;
    fixed_t pending[$];
    int errors;
    int matched;

    function fixed_t to_q14_17(logic [FloatWidth-1:0] bits);
      logic neg;
      logic [7:0] expo;
      logic [31:0] sig;
      logic [31:0] mag;
      logic [31:0] q;
      logic [31:0] rem;
      logic [31:0] half;
      int sh;
      neg  = bits[31];
      expo = bits[30:23];
      sig  = {8'd0, 1'b1, bits[22:0]};
      if (expo < EXP_FLUSH_BELOW) return '0;
      if (expo >= EXP_SATURATE_AT) return neg ? FIX_MOST_NEG : FIX_MOST_POS;
      if (expo >= EXP_UNIT_SHIFT) begin
        mag = sig << (int'(expo) - int'(EXP_UNIT_SHIFT));
      end else begin
        sh   = int'(EXP_UNIT_SHIFT) - int'(expo);
        q    = sig >> sh;
        rem  = sig & ((32'd1 << sh) - 32'd1);
        half = 32'd1 << (sh - 1);
        mag  = q + ((rem > half || (rem == half && q[0])) ? 32'd1 : 32'd0);
      end
      return neg ? fixed_t'(32'd0 - mag) : fixed_t'(mag);
    endfunction

    function void note_float(logic [FloatWidth-1:0] bits);
      pending.push_back(to_q14_17(bits));
    endfunction

    function void check_fixed(fixed_t got);
      fixed_t want;
      if (pending.size() == 0) begin
        $error("fixed_value transfer with nothing outstanding: got %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $error("fixed_value mismatch: expected %h, actual %h", want, got);
        errors++;
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   src_idle_pct;
  int   sink_stall_pct;
  int   floats_sent;

  fixed_scoreboard sb;

  f2x_float_if float_in ();
  f2x_fixed_if fixed_out ();

  float_to_fixed_converter DUT (
    .clk       (clk),
    .rst       (rst),
    .float_in  (float_in),
    .fixed_out (fixed_out)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(negedge clk) begin
    fixed_out.ready = ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && fixed_out.valid && fixed_out.ready) sb.check_fixed(fixed_out.fixed_value);
  end

  task automatic send_float(input logic [FloatWidth-1:0] bits);
    bit done;
    done = 1'b0;
    while (!done) begin
      @(negedge clk);
      if ($urandom_range(99) < src_idle_pct) begin
        float_in.valid      = 1'b0;
        float_in.float_bits = $urandom();
      end else begin
        float_in.valid      = 1'b1;
        float_in.float_bits = bits;
      end
      @(posedge clk);
      if (float_in.valid && float_in.ready) begin
        sb.note_float(bits);
        floats_sent++;
        done = 1'b1;
      end
    end
  endtask

  function automatic logic [FloatWidth-1:0] random_float();
    logic [7:0]  expo;
    logic [22:0] frac;
    int          sh;
    int          pick;
    pick = $urandom_range(99);
    frac = 23'($urandom());
    if (pick < 60) begin
      expo = 8'($urandom_range(145, 105));
    end else if (pick < 78) begin
      // exact halfway remainder, both even and odd quotients
      expo = 8'($urandom_range(132, 109));
      sh   = int'(EXP_UNIT_SHIFT) - int'(expo);
      if (sh >= 24) frac = '0;
      else frac = (frac & ~((23'd1 << sh) - 23'd1)) | (23'd1 << (sh - 1));
    end else begin
      return $urandom();
    end
    return {1'($urandom()), expo, frac};
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_float(random_float());
  endtask

  initial begin
    logic [FloatWidth-1:0] corners[$];
    corners = {
      32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807f_ffff,
      32'h367f_ffff, 32'h3680_0000, 32'h3680_0001, 32'hb680_0000,
      32'hb6ff_ffff, 32'h3f80_0000, 32'hbf80_0000, 32'h3f00_0000,
      32'h4200_0000, 32'h4200_0001, 32'h4200_0003, 32'h4280_0000,
      32'h467f_ffff, 32'hc67f_ffff, 32'h4680_0000, 32'hc680_0000,
      32'h7f80_0000, 32'hff80_0000, 32'h7fc0_0000, 32'hffff_ffff,
      32'h7f7f_ffff
    };
    sb                  = new();
    rst                 = 1'b1;
    float_in.valid      = 1'b0;
    float_in.float_bits = '0;
    fixed_out.ready     = 1'b0;
    src_idle_pct        = 26;
    sink_stall_pct      = 59;
    floats_sent         = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (corners[i]) send_float(corners[i]);
    run_random(583);

    src_idle_pct   = 59;
    sink_stall_pct = 26;
    run_random(583);

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    run_random(584);

    @(negedge clk);
    float_in.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Converted %0d floats (%0d corner values) under three flow-control mixes,",
             floats_sent, corners.size());
    $display("%0d results matched, %0d mismatches.", sb.matched, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #200us;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
